// ===== rtl/rmsd_pkg.sv =====
// Package for the RGB matrix scan driver: panel geometry, store word layout,
// function and register codes, and the structs passed between the modules.
// No dependencies.
package rmsd_pkg;

  // Panel geometry
  localparam int PANEL_COLUMNS = 32;
  localparam int SCAN_ROWS     = 16;
  localparam int FRAME_BYTES   = 128;
  localparam int STORE_PIXELS  = PANEL_COLUMNS * SCAN_ROWS * 2;

  // Store word layout: one word holds eight pixels of one row
  localparam int PIX_W   = 3;
  localparam int LANES   = 8;
  localparam int LANE_W  = $clog2(LANES);
  localparam int WORD_W  = LANES * PIX_W;
  localparam int COL_W   = $clog2(PANEL_COLUMNS);
  localparam int ROW_W   = $clog2(SCAN_ROWS);
  localparam int WSEL_W  = COL_W - LANE_W;
  localparam int WADDR_W = ROW_W + WSEL_W;
  localparam int WORDS   = SCAN_ROWS * PANEL_COLUMNS / LANES;

  // Configuration
  localparam int                CFG_IDX_W   = 1;
  localparam int                CFG_DATA_W  = 16;
  localparam int                DWELL_W     = 16;
  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1000;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_PIXEL = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DWELL  = 1'b0,
    CFG_ENABLE = 1'b1
  } cfg_idx_e;

  // Store access request from the controller
  typedef struct packed {
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               wr_en;
    logic               wr_half;
    logic [WADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               clear;
  } store_req_t;

  // Scan step that the current tick performs
  typedef struct packed {
    logic             shift;
    logic             latch;
    logic             lit;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } scan_info_t;

endpackage

// ===== rtl/rmsd_req_if.sv =====
// Input item channel of the RGB matrix scan driver.
// Depends on nothing; field widths follow the item format.
interface rmsd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [6:0] byte_index;
  logic [7:0] byte_value;
  logic [4:0] pix_x;
  logic [4:0] pix_y;
  logic       red;
  logic       green;
  logic       blue;

  modport source (output valid, func, byte_index, byte_value, pix_x, pix_y,
                  red, green, blue, input ready);
  modport sink   (input valid, func, byte_index, byte_value, pix_x, pix_y,
                  red, green, blue, output ready);
endinterface

// ===== rtl/rmsd_rsp_if.sv =====
// Result item channel of the RGB matrix scan driver.
// Depends on nothing; field widths follow the result format.
interface rmsd_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] upper_rgb;
  logic [2:0] lower_rgb;
  logic       shift_clock;
  logic       latch_pulse;
  logic       output_enable;
  logic [3:0] row_select;

  modport source (output valid, upper_rgb, lower_rgb, shift_clock, latch_pulse,
                  output_enable, row_select, input ready);
  modport sink   (input valid, upper_rgb, lower_rgb, shift_clock, latch_pulse,
                  output_enable, row_select, output ready);
endinterface

// ===== rtl/rgb_matrix_scan_driver_unit.sv =====
// Top level of the RGB matrix scan driver: item controller, frame store and
// scan sequencer. Depends on rmsd_pkg, rmsd_req_if, rmsd_rsp_if,
// rmsd_store and rmsd_scan.
//
//   port      direction  handshake      carries
//   req_i     in         valid/ready    func, byte_index, byte_value,
//                                       pix_x, pix_y, red, green, blue
//   rsp_o     out        valid/ready    upper_rgb, lower_rgb, shift_clock,
//                                       latch_pulse, output_enable, row_select
//   cfg_*_i   in         write enable   dwell_ticks (0), scan_enable (1)
//
// Byte loads and clears need no ST_EXEC step; ticks and pixel writes go
// through ST_EXEC for the registered frame store read (pixel writes read,
// modify and write back a word). A clear drops per-word valid bits at once.
// Reset clears the store and the scan state. An item is taken only while the
// result register is empty or draining, so a stalled result stalls input.
module rgb_matrix_scan_driver_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rmsd_req_if.sink                        req_i,
  rmsd_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [rmsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmsd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                          state_q, state_d;
  logic                          accept;
  logic                          tick_fire;
  rmsd_pkg::func_e               func;
  rmsd_pkg::store_req_t          sreq;
  rmsd_pkg::scan_info_t          info;
  logic [rmsd_pkg::WORD_W-1:0]   rd_upper;
  logic [rmsd_pkg::WORD_W-1:0]   rd_lower;
  logic [rmsd_pkg::COL_W-1:0]    colm;
  logic                          pix_ok;
  logic                          byte_ok;
  logic [rmsd_pkg::WORD_W-1:0]   byte_word;
  logic [rmsd_pkg::WORD_W-1:0]   base_word;
  logic [rmsd_pkg::WORD_W-1:0]   mod_word;

  // Pending item between accept and memory data
  logic                          pend_tick_q, pend_tick_d;
  rmsd_pkg::scan_info_t          pend_info_q, pend_info_d;
  logic                          pend_wr_q, pend_wr_d;
  logic                          pend_half_q, pend_half_d;
  logic [rmsd_pkg::WADDR_W-1:0]  pend_addr_q, pend_addr_d;
  logic [rmsd_pkg::LANE_W-1:0]   pend_lane_q, pend_lane_d;
  logic [rmsd_pkg::PIX_W-1:0]    pend_rgb_q, pend_rgb_d;

  // Result register
  logic                          out_valid_q, out_valid_d;
  logic [2:0]                    out_upper_q, out_upper_d;
  logic [2:0]                    out_lower_q, out_lower_d;
  logic                          out_sclk_q, out_sclk_d;
  logic                          out_lat_q, out_lat_d;
  logic                          out_oe_q, out_oe_d;
  logic [3:0]                    out_row_q, out_row_d;

  assign req_i.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign func        = rmsd_pkg::func_e'(req_i.func);
  assign tick_fire   = accept && (func == rmsd_pkg::FUNC_TICK);

  // Store address of a pixel write, column mirrored
  assign colm    = rmsd_pkg::COL_W'(rmsd_pkg::PANEL_COLUMNS - 1)
                 - req_i.pix_x[rmsd_pkg::COL_W-1:0];
  assign pix_ok  = (int'(req_i.pix_x) < rmsd_pkg::PANEL_COLUMNS)
                && (int'(req_i.pix_y) < 2 * rmsd_pkg::SCAN_ROWS);
  assign byte_ok = (int'(req_i.byte_index) < rmsd_pkg::FRAME_BYTES)
                && (int'(req_i.byte_index) < 2 * rmsd_pkg::WORDS);

  // Expand a monochrome byte to eight white or black pixels
  always_comb begin
    for (int j = 0; j < rmsd_pkg::LANES; j++) begin
      byte_word[j*rmsd_pkg::PIX_W +: rmsd_pkg::PIX_W] =
        req_i.byte_value[j] ? {rmsd_pkg::PIX_W{1'b1}} : '0;
    end
  end

  // Merge one pixel into the word read back
  always_comb begin
    base_word = pend_half_q ? rd_lower : rd_upper;
    mod_word  = base_word;
    mod_word[pend_lane_q*rmsd_pkg::PIX_W +: rmsd_pkg::PIX_W] = pend_rgb_q;
  end

  // Decode items and sequence the store accesses
  always_comb begin
    state_d     = state_q;
    sreq        = '0;
    pend_tick_d = pend_tick_q;
    pend_info_d = pend_info_q;
    pend_wr_d   = pend_wr_q;
    pend_half_d = pend_half_q;
    pend_addr_d = pend_addr_q;
    pend_lane_d = pend_lane_q;
    pend_rgb_d  = pend_rgb_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_upper_d = out_upper_q;
    out_lower_d = out_lower_q;
    out_sclk_d  = out_sclk_q;
    out_lat_d   = out_lat_q;
    out_oe_d    = out_oe_q;
    out_row_d   = out_row_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (func)
            rmsd_pkg::FUNC_TICK: begin
              sreq.rd_en   = 1'b1;
              sreq.rd_addr = {info.row, info.col[rmsd_pkg::COL_W-1:rmsd_pkg::LANE_W]};
              pend_tick_d  = 1'b1;
              pend_info_d  = info;
              pend_lane_d  = info.col[rmsd_pkg::LANE_W-1:0];
              state_d      = ST_EXEC;
            end
            rmsd_pkg::FUNC_BYTE: begin
              sreq.wr_en   = byte_ok;
              sreq.wr_half = req_i.byte_index[rmsd_pkg::WADDR_W];
              sreq.wr_addr = req_i.byte_index[rmsd_pkg::WADDR_W-1:0];
              sreq.wr_data = byte_word;
            end
            rmsd_pkg::FUNC_PIXEL: begin
              sreq.rd_en   = 1'b1;
              sreq.rd_addr = {req_i.pix_y[rmsd_pkg::ROW_W-1:0],
                              colm[rmsd_pkg::COL_W-1:rmsd_pkg::LANE_W]};
              pend_tick_d  = 1'b0;
              pend_wr_d    = pix_ok;
              pend_half_d  = req_i.pix_y[rmsd_pkg::ROW_W];
              pend_addr_d  = sreq.rd_addr;
              pend_lane_d  = colm[rmsd_pkg::LANE_W-1:0];
              pend_rgb_d   = {req_i.blue, req_i.green, req_i.red};
              state_d      = ST_EXEC;
            end
            rmsd_pkg::FUNC_CLEAR: begin
              sreq.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_EXEC: begin
        if (pend_tick_q) begin
          out_valid_d = 1'b1;
          out_upper_d = pend_info_q.shift
                      ? rd_upper[pend_lane_q*rmsd_pkg::PIX_W +: rmsd_pkg::PIX_W] : '0;
          out_lower_d = pend_info_q.shift
                      ? rd_lower[pend_lane_q*rmsd_pkg::PIX_W +: rmsd_pkg::PIX_W] : '0;
          out_sclk_d  = pend_info_q.shift;
          out_lat_d   = pend_info_q.latch;
          out_oe_d    = pend_info_q.lit;
          out_row_d   = 4'(pend_info_q.row);
        end else begin
          sreq.wr_en   = pend_wr_q;
          sreq.wr_half = pend_half_q;
          sreq.wr_addr = pend_addr_q;
          sreq.wr_data = mod_word;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold pending item and result payload
  always_ff @(posedge clk_i) begin
    pend_tick_q <= pend_tick_d;
    pend_info_q <= pend_info_d;
    pend_wr_q   <= pend_wr_d;
    pend_half_q <= pend_half_d;
    pend_addr_q <= pend_addr_d;
    pend_lane_q <= pend_lane_d;
    pend_rgb_q  <= pend_rgb_d;
    out_upper_q <= out_upper_d;
    out_lower_q <= out_lower_d;
    out_sclk_q  <= out_sclk_d;
    out_lat_q   <= out_lat_d;
    out_oe_q    <= out_oe_d;
    out_row_q   <= out_row_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.upper_rgb     = out_upper_q;
  assign rsp_o.lower_rgb     = out_lower_q;
  assign rsp_o.shift_clock   = out_sclk_q;
  assign rsp_o.latch_pulse   = out_lat_q;
  assign rsp_o.output_enable = out_oe_q;
  assign rsp_o.row_select    = out_row_q;

  rmsd_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sreq),
    .upper_o (rd_upper),
    .lower_o (rd_lower)
  );

  rmsd_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tick_i     (tick_fire),
    .info_o     (info)
  );

endmodule

// ===== rtl/rmsd_store.sv =====
// Frame store: two synchronous memories (upper and lower panel half) of
// eight-pixel words, with per-word valid bits so a clear drops all at once.
// Depends on rmsd_pkg.
module rmsd_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rmsd_pkg::store_req_t        req_i,
  output logic [rmsd_pkg::WORD_W-1:0] upper_o,
  output logic [rmsd_pkg::WORD_W-1:0] lower_o
);

  logic [rmsd_pkg::WORD_W-1:0] mem_upper [rmsd_pkg::WORDS];
  logic [rmsd_pkg::WORD_W-1:0] mem_lower [rmsd_pkg::WORDS];
  logic [rmsd_pkg::WORDS-1:0]  vld_upper_q;
  logic [rmsd_pkg::WORDS-1:0]  vld_lower_q;
  logic [rmsd_pkg::WORD_W-1:0] rd_upper_q;
  logic [rmsd_pkg::WORD_W-1:0] rd_lower_q;
  logic                        rd_vu_q;
  logic                        rd_vl_q;

  // Write one word into the selected half
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && !req_i.wr_half) begin
      mem_upper[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.wr_en && req_i.wr_half) begin
      mem_lower[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read both halves at the same word address
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_upper_q <= mem_upper[req_i.rd_addr];
      rd_lower_q <= mem_lower[req_i.rd_addr];
    end
  end

  // Track written words; clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_upper_q <= '0;
      vld_lower_q <= '0;
      rd_vu_q     <= 1'b0;
      rd_vl_q     <= 1'b0;
    end else begin
      if (req_i.clear) begin
        vld_upper_q <= '0;
        vld_lower_q <= '0;
      end else if (req_i.wr_en) begin
        if (req_i.wr_half) begin
          vld_lower_q[req_i.wr_addr] <= 1'b1;
        end else begin
          vld_upper_q[req_i.wr_addr] <= 1'b1;
        end
      end
      if (req_i.rd_en) begin
        rd_vu_q <= vld_upper_q[req_i.rd_addr];
        rd_vl_q <= vld_lower_q[req_i.rd_addr];
      end
    end
  end

  // Unwritten words read as black
  assign upper_o = rd_vu_q ? rd_upper_q : '0;
  assign lower_o = rd_vl_q ? rd_lower_q : '0;

endmodule

// ===== rtl/rmsd_scan.sv =====
// Scan sequencer: configuration registers and the row, column, phase and
// dwell counters of the refresh scan. Depends on rmsd_pkg.
module rmsd_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rmsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            tick_i,
  output rmsd_pkg::scan_info_t            info_o
);

  localparam logic [1:0] PH_SHIFT = 2'd0;
  localparam logic [1:0] PH_LATCH = 2'd1;
  localparam logic [1:0] PH_DWELL = 2'd2;

  logic [1:0]                   phase_q, phase_d;
  logic [rmsd_pkg::ROW_W-1:0]   row_q, row_d;
  logic [rmsd_pkg::COL_W-1:0]   col_q, col_d;
  logic [rmsd_pkg::DWELL_W-1:0] cnt_q, cnt_d;
  logic [rmsd_pkg::DWELL_W-1:0] cnt_dec;
  logic [rmsd_pkg::DWELL_W-1:0] dwell_q;
  logic                         en_q;
  logic                         is_latch;
  logic                         is_dwell;

  assign is_latch = (phase_q == PH_LATCH);
  assign is_dwell = (phase_q == PH_DWELL);
  assign cnt_dec  = (cnt_q != '0) ? cnt_q - 1'b1 : '0;

  // Describe the step the next tick performs
  always_comb begin
    info_o.shift = en_q && !is_latch && !is_dwell;
    info_o.latch = en_q && is_latch;
    info_o.lit   = en_q && (is_latch || is_dwell);
    info_o.row   = row_q;
    info_o.col   = col_q;
  end

  // Advance the scan on an enabled tick
  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    cnt_d   = cnt_q;
    if (tick_i && en_q) begin
      if (is_latch) begin
        cnt_d   = (dwell_q == '0) ? rmsd_pkg::DWELL_W'(1) : dwell_q;
        phase_d = PH_DWELL;
      end else if (is_dwell) begin
        cnt_d = cnt_dec;
        if (cnt_dec == '0) begin
          row_d   = (row_q == rmsd_pkg::ROW_W'(rmsd_pkg::SCAN_ROWS - 1)) ? '0
                                                                       : row_q + 1'b1;
          col_d   = '0;
          phase_d = PH_SHIFT;
        end
      end else begin
        if (col_q == rmsd_pkg::COL_W'(rmsd_pkg::PANEL_COLUMNS - 1)) begin
          col_d   = '0;
          phase_d = PH_LATCH;
        end else begin
          col_d   = col_q + 1'b1;
          phase_d = PH_SHIFT;
        end
      end
    end
  end

  // Hold scan state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SHIFT;
      row_q   <= '0;
      col_q   <= '0;
      cnt_q   <= '0;
      dwell_q <= rmsd_pkg::DWELL_RESET;
      en_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rmsd_pkg::CFG_DWELL:  dwell_q <= cfg_data_i[rmsd_pkg::DWELL_W-1:0];
          rmsd_pkg::CFG_ENABLE: en_q    <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench for rgb_matrix_scan_driver_unit: drives random and directed items,
// predicts every scan result in a behavioral panel model and checks it.
// Depends on rmsd_pkg, rmsd_req_if, rmsd_rsp_if and the unit itself.
`timescale 1ns / 1ps

module tb_top;
  import rmsd_pkg::*;

  typedef struct packed {
    func_e      func;
    logic [6:0] byte_index;
    logic [7:0] byte_value;
    logic [4:0] pix_x;
    logic [4:0] pix_y;
    logic       red;
    logic       green;
    logic       blue;
  } panel_item_t;

  typedef struct packed {
    logic [2:0] upper_rgb;
    logic [2:0] lower_rgb;
    logic       shift_clock;
    logic       latch_pulse;
    logic       output_enable;
    logic [3:0] row_select;
  } scan_out_t;

  typedef enum logic [1:0] {
    SCAN_SHIFT = 2'd0,
    SCAN_LATCH = 2'd1,
    SCAN_DWELL = 2'd2
  } scan_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rmsd_req_if req_if ();
  rmsd_rsp_if rsp_if ();

  rgb_matrix_scan_driver_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Panel model state and its copy of the registers
  logic [2:0]      pix_mem [0:STORE_PIXELS-1];
  logic [3:0]      row_q;
  logic [4:0]      col_q;
  scan_phase_e     phase_q;
  logic [15:0]     dwell_left;
  logic [15:0]     dwell_cfg;
  logic            enable_cfg;

  panel_item_t item_q [$];
  scan_out_t   scan_out_q [$];

  int errors = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one accepted item to the panel model; queue the scan result of a tick
  task automatic model_panel_item(input panel_item_t it);
    scan_out_t r;
    begin
      r = '0;
      case (it.func)
        FUNC_BYTE: begin
          for (int j = 0; j < 8; j++)
            pix_mem[int'(it.byte_index) * 8 + j] = it.byte_value[j] ? 3'd7 : 3'd0;
        end
        FUNC_PIXEL: begin
          pix_mem[{it.pix_y, 5'd31 - it.pix_x}] = {it.blue, it.green, it.red};
        end
        FUNC_CLEAR: begin
          for (int k = 0; k < STORE_PIXELS; k++) pix_mem[k] = 3'd0;
        end
        default: begin
          r.row_select = row_q;
          if (enable_cfg) begin
            case (phase_q)
              SCAN_LATCH: begin
                r.latch_pulse   = 1'b1;
                r.output_enable = 1'b1;
                dwell_left = (dwell_cfg == 16'd0) ? 16'd1 : dwell_cfg;
                phase_q = SCAN_DWELL;
              end
              SCAN_DWELL: begin
                r.output_enable = 1'b1;
                if (dwell_left != 16'd0) dwell_left = dwell_left - 16'd1;
                if (dwell_left == 16'd0) begin
                  row_q   = row_q + 4'd1;
                  col_q   = 5'd0;
                  phase_q = SCAN_SHIFT;
                end
              end
              default: begin
                r.upper_rgb   = pix_mem[{row_q, col_q}];
                r.lower_rgb   = pix_mem[{1'b1, row_q, col_q}];
                r.shift_clock = 1'b1;
                if (col_q == 5'd31) begin
                  col_q   = 5'd0;
                  phase_q = SCAN_LATCH;
                end else begin
                  col_q = col_q + 5'd1;
                end
              end
            endcase
          end
          scan_out_q.push_back(r);
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    begin
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    end
  endtask

  // Drive items from the pending queue, with random idle bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (send_gap == 0 && send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        send_gap = $urandom_range(11, 1);
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        panel_item_t nxt;
        nxt = item_q.pop_front();
        req_if.valid      <= 1'b1;
        req_if.func       <= nxt.func;
        req_if.byte_index <= nxt.byte_index;
        req_if.byte_value <= nxt.byte_value;
        req_if.pix_x      <= nxt.pix_x;
        req_if.pix_y      <= nxt.pix_y;
        req_if.red        <= nxt.red;
        req_if.green      <= nxt.green;
        req_if.blue       <= nxt.blue;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Drive result ready: long hold-off on request, otherwise random stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (recv_gap == 0 && recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct)
        recv_gap = $urandom_range(11, 1);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Check accepted results, then feed accepted items to the model
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (scan_out_q.size() == 0) begin
        $display("%0t: unexpected result item: expected none, actual %0h", $time,
                 {rsp_if.upper_rgb, rsp_if.lower_rgb, rsp_if.shift_clock,
                  rsp_if.latch_pulse, rsp_if.output_enable, rsp_if.row_select});
        errors++;
      end else begin
        scan_out_t e;
        e = scan_out_q.pop_front();
        check_field("upper_rgb", e.upper_rgb, rsp_if.upper_rgb);
        check_field("lower_rgb", e.lower_rgb, rsp_if.lower_rgb);
        check_field("shift_clock", e.shift_clock, rsp_if.shift_clock);
        check_field("latch_pulse", e.latch_pulse, rsp_if.latch_pulse);
        check_field("output_enable", e.output_enable, rsp_if.output_enable);
        check_field("row_select", e.row_select, rsp_if.row_select);
      end
    end
    if (rst_ni && req_if.valid && req_if.ready)
      model_panel_item({func_e'(req_if.func), req_if.byte_index, req_if.byte_value,
                        req_if.pix_x, req_if.pix_y, req_if.red, req_if.green,
                        req_if.blue});
  end

  function automatic panel_item_t build_item(input func_e f, input logic [6:0] bi,
                                             input logic [7:0] bv, input logic [4:0] x,
                                             input logic [4:0] y, input logic [2:0] rgb);
    panel_item_t it;
    it.func       = f;
    it.byte_index = bi;
    it.byte_value = bv;
    it.pix_x      = x;
    it.pix_y      = y;
    it.red        = rgb[0];
    it.green      = rgb[1];
    it.blue       = rgb[2];
    return it;
  endfunction

  // Write one register while the unit is idle and mirror it in the model
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data;
      case (idx)
        CFG_DWELL:  dwell_cfg = data;
        default:    enable_cfg = data[0];
      endcase
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
    end
  endtask

  // Hold until every item is taken and every result has come, then let the pipe drain
  task automatic wait_idle;
    begin
      while (item_q.size() != 0 || req_if.valid || scan_out_q.size() != 0)
        @(posedge clk_i);
      repeat (10) @(posedge clk_i);
    end
  endtask

  // Queue n random items, mostly ticks, then drain
  task automatic run_phase(input int n, input int tick_pct, input int sidle,
                           input int ridle, input bit long_hold);
    int r;
    func_e f;
    begin
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(99);
        if (r < tick_pct) begin
          f = FUNC_TICK;
        end else begin
          r = $urandom_range(99);
          if (r < 45) f = FUNC_BYTE;
          else if (r < 95) f = FUNC_PIXEL;
          else f = FUNC_CLEAR;
        end
        item_q.push_back(build_item(f, 7'($urandom), 8'($urandom), 5'($urandom),
                                    5'($urandom), 3'($urandom)));
      end
      if (long_hold) hold_req++;
      wait_idle();
    end
  endtask

  // Stimulus sequence
  initial begin
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_TICK;
    req_if.byte_index = '0;
    req_if.byte_value = '0;
    req_if.pix_x      = '0;
    req_if.pix_y      = '0;
    req_if.red        = 1'b0;
    req_if.green      = 1'b0;
    req_if.blue       = 1'b0;
    rsp_if.ready      = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_DWELL;
    cfg_data_i        = '0;
    for (int k = 0; k < STORE_PIXELS; k++) pix_mem[k] = 3'd0;
    row_q      = 4'd0;
    col_q      = 5'd0;
    phase_q    = SCAN_SHIFT;
    dwell_left = 16'd0;
    dwell_cfg  = DWELL_RESET;
    enable_cfg = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: disabled ticks, field extremes, every function, mirrored corners
    send_idle_pct = 20;
    recv_idle_pct = 20;
    item_q.push_back(build_item(FUNC_TICK, 7'h7f, 8'hff, 5'd31, 5'd31, 3'd7));
    item_q.push_back(build_item(FUNC_BYTE, 7'd0, 8'hff, 5'd0, 5'd0, 3'd0));
    item_q.push_back(build_item(FUNC_BYTE, 7'd127, 8'h81, 5'd31, 5'd31, 3'd7));
    item_q.push_back(build_item(FUNC_BYTE, 7'd64, 8'h5a, 5'd0, 5'd0, 3'd0));
    item_q.push_back(build_item(FUNC_BYTE, 7'd1, 8'h00, 5'd0, 5'd0, 3'd0));
    item_q.push_back(build_item(FUNC_PIXEL, 7'd0, 8'h00, 5'd0, 5'd0, 3'd1));
    item_q.push_back(build_item(FUNC_PIXEL, 7'h7f, 8'hff, 5'd31, 5'd31, 3'd7));
    item_q.push_back(build_item(FUNC_PIXEL, 7'd0, 8'h00, 5'd31, 5'd0, 3'd2));
    item_q.push_back(build_item(FUNC_PIXEL, 7'd0, 8'h00, 5'd0, 5'd31, 3'd4));
    item_q.push_back(build_item(FUNC_PIXEL, 7'd0, 8'h00, 5'd0, 5'd16, 3'd6));
    item_q.push_back(build_item(FUNC_PIXEL, 7'd0, 8'h00, 5'd31, 5'd15, 3'd5));
    item_q.push_back(build_item(FUNC_TICK, 7'd0, 8'h00, 5'd0, 5'd0, 3'd0));
    item_q.push_back(build_item(FUNC_CLEAR, 7'h7f, 8'hff, 5'd31, 5'd31, 3'd7));
    item_q.push_back(build_item(FUNC_BYTE, 7'd0, 8'h3c, 5'd0, 5'd0, 3'd0));
    item_q.push_back(build_item(FUNC_BYTE, 7'd64, 8'hc3, 5'd0, 5'd0, 3'd0));
    item_q.push_back(build_item(FUNC_PIXEL, 7'd0, 8'h00, 5'd0, 5'd0, 3'd3));
    item_q.push_back(build_item(FUNC_TICK, 7'h55, 8'haa, 5'd21, 5'd10, 3'd5));
    wait_idle();

    // Zero dwell with the scan running
    write_reg(CFG_DWELL, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);
    run_phase(300, 75, 25, 25, 1'b0);

    write_reg(CFG_DWELL, 16'd1);
    run_phase(300, 75, 0, 40, 1'b0);

    // Random short dwell; hold off results so the unit backs up
    write_reg(CFG_DWELL, 16'($urandom_range(24, 2)));
    run_phase(300, 80, 30, 0, 1'b1);

    // Scan frozen
    write_reg(CFG_ENABLE, 16'd0);
    run_phase(80, 60, 20, 20, 1'b0);

    write_reg(CFG_ENABLE, 16'd1);
    write_reg(CFG_DWELL, 16'd3);
    run_phase(250, 80, 15, 15, 1'b0);

    // Longest dwell; the following change only lands at the next latch
    write_reg(CFG_DWELL, 16'hffff);
    run_phase(250, 85, 20, 20, 1'b0);

    // Final stretch without idling
    write_reg(CFG_DWELL, 16'd2);
    run_phase(170, 75, 0, 0, 1'b0);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
